// File: src/assert_macros.svh
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CSR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define CSR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/csr_pkg.sv
// Shared types and constants for the column statistics reduction block.
package csr_pkg;

  localparam int VAL_W      = 16;
  localparam int WGT_W      = 16;
  localparam int STAT_W     = 40;
  localparam int CIDX_W     = 10;
  localparam int MISS_W     = 11;
  localparam int CC_W       = 11;
  localparam int RC_W       = 13;
  localparam int SEL_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [STAT_W-1:0] STAT_MAX = {1'b0, {(STAT_W-1){1'b1}}};

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STATISTIC     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SKIP_MISSING  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MISSING_VALUE = 3'd4;

  // statistic codes
  localparam logic [SEL_W-1:0] STAT_MIN   = 3'd0;
  localparam logic [SEL_W-1:0] STAT_MAXV  = 3'd1;
  localparam logic [SEL_W-1:0] STAT_RANGE = 3'd2;
  localparam logic [SEL_W-1:0] STAT_PVAR  = 3'd3;
  localparam logic [SEL_W-1:0] STAT_SVAR  = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_UPDATE,
    S_MUL_GO,
    S_MUL_RUN,
    S_PREP,
    S_DIV_RUN,
    S_EMIT
  } ctl_state_t;

  typedef struct packed {
    logic accept;
    logic prod;
    logic upd;
    logic mul_go;
    logic mul_step;
    logic prep;
    logic div_step;
    logic load_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic last_row;
    logic is_var;
    logic mul_done;
    logic mul_last;
    logic var_miss;
    logic div_done;
    logic out_free;
  } dp_sts_t;

endpackage

// File: src/csr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module csr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/csr_ctrl.sv
// Controller state machine sequencing accept, update, multiply, divide and emit.
`include "assert_macros.svh"
module csr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  csr_pkg::dp_sts_t  sts,
  output csr_pkg::ctl_cmd_t cmd
);
  import csr_pkg::*;

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_READ;
        end
      end
      S_READ: begin
        cmd.prod  = 1'b1;
        state_nxt = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.upd = 1'b1;
        if (!sts.last_row) state_nxt = S_IDLE;
        else if (sts.is_var) state_nxt = S_MUL_GO;
        else state_nxt = S_EMIT;
      end
      S_MUL_GO: begin
        cmd.mul_go = 1'b1;
        state_nxt  = S_MUL_RUN;
      end
      S_MUL_RUN: begin
        cmd.mul_step = 1'b1;
        if (sts.mul_done) state_nxt = sts.mul_last ? S_PREP : S_MUL_GO;
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = sts.var_miss ? S_EMIT : S_DIV_RUN;
      end
      S_DIV_RUN: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  `CSR_ASSERT_NXT(a_accept_reads, cmd.accept, state_r == S_READ, "accept did not start a read")
  `CSR_ASSERT_NXT(a_emit_returns, cmd.load_out, state_r == S_IDLE, "emit did not return to idle")
  `CSR_ASSERT_IMP(a_stall_busy, state_r != S_IDLE, in_stall, "input open while busy")

endmodule

// File: src/csr_datapath.sv
// Datapath: config registers, positions, column update, serial multiplier and divider.
`include "assert_macros.svh"
module csr_datapath #(
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_ROWS    = 4096,
  localparam int RB     = $clog2(MAX_ROWS),
  localparam int CPW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1,
  localparam int SW_W   = 16 + RB,
  localparam int SWW_W  = 32 + RB,
  localparam int SWX_W  = 33 + RB,
  localparam int SWXX_W = 46 + RB,
  localparam int ENT_W  = 33 + SWX_W + SWXX_W + SW_W + SWW_W
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [csr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [csr_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic signed [csr_pkg::VAL_W-1:0]     in_sample_value,
  input  logic [csr_pkg::WGT_W-1:0]            in_sample_weight,
  input  csr_pkg::ctl_cmd_t                    cmd,
  output csr_pkg::dp_sts_t                     sts,
  output logic                                 ram_we,
  output logic [CPW-1:0]                       ram_waddr,
  output logic [ENT_W-1:0]                     ram_wdata,
  output logic                                 ram_re,
  output logic [CPW-1:0]                       ram_raddr,
  input  logic [ENT_W-1:0]                     ram_rdata,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [csr_pkg::CIDX_W-1:0]           out_column_index,
  output logic signed [csr_pkg::STAT_W-1:0]    out_stat_value,
  output logic                                 out_is_missing,
  output logic                                 out_last_column,
  output logic [csr_pkg::MISS_W-1:0]           out_missing_total
);
  import csr_pkg::*;

  localparam int RPW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int MA_W  = SWXX_W;
  localparam int MB_W  = SWX_W;
  localparam int P_W   = MA_W + MB_W;
  localparam int WW_W  = 2 * SW_W;
  localparam int NUM_W = P_W + 8;
  localparam int MCW   = $clog2(MB_W + 1);
  localparam int DCW   = $clog2(NUM_W + 1);

  // configuration
  logic [CC_W-1:0]         column_count_r;
  logic [RC_W-1:0]         row_count_r;
  logic [SEL_W-1:0]        statistic_r;
  logic                    skip_missing_r;
  logic signed [VAL_W-1:0] missing_value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_count_r  <= CC_W'(1);
      row_count_r     <= RC_W'(1);
      statistic_r     <= STAT_MIN;
      skip_missing_r  <= 1'b0;
      missing_value_r <= {1'b1, {(VAL_W-1){1'b0}}};
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COLUMN_COUNT:  column_count_r  <= cfg_data[CC_W-1:0];
        CFG_ROW_COUNT:     row_count_r     <= cfg_data[RC_W-1:0];
        CFG_STATISTIC:     statistic_r     <= cfg_data[SEL_W-1:0];
        CFG_SKIP_MISSING:  skip_missing_r  <= cfg_data[0];
        CFG_MISSING_VALUE: missing_value_r <= signed'(cfg_data[VAL_W-1:0]);
        default: ;
      endcase
    end
  end

  // positions
  logic [CPW-1:0] col_pos_r, col_pos_nxt;
  logic [RPW-1:0] row_pos_r, row_pos_nxt;
  logic [31:0]    ncols, nrows;
  logic           last_col, last_row;

  always_comb begin
    ncols = (column_count_r == '0) ? 32'd1 : 32'(column_count_r);
    if (ncols > 32'(MAX_COLUMNS)) ncols = 32'(MAX_COLUMNS);
    nrows = (row_count_r == '0) ? 32'd1 : 32'(row_count_r);
    if (nrows > 32'(MAX_ROWS)) nrows = 32'(MAX_ROWS);
    last_col = (32'(col_pos_r) + 32'd1) >= ncols;
    last_row = (32'(row_pos_r) + 32'd1) >= nrows;
    col_pos_nxt = last_col ? '0 : col_pos_r + CPW'(1);
    row_pos_nxt = row_pos_r;
    if (last_col) row_pos_nxt = last_row ? '0 : row_pos_r + RPW'(1);
  end

  // captured item
  logic signed [VAL_W-1:0] x_r;
  logic [WGT_W-1:0]        w_r;
  logic [30:0]             xx_r;
  logic                    use_r, row0_r, lastrow_r, lastcol_r;
  logic [CPW-1:0]          col_r;
  logic signed [32:0]      wx_r;
  logic [45:0]             wxx_r;
  logic [31:0]             wsq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_pos_r <= '0;
      row_pos_r <= '0;
    end else if (cmd.accept) begin
      col_pos_r <= col_pos_nxt;
      row_pos_r <= row_pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      x_r       <= in_sample_value;
      w_r       <= in_sample_weight;
      xx_r      <= 31'(in_sample_value * in_sample_value);
      use_r     <= !(skip_missing_r && (in_sample_value == missing_value_r));
      row0_r    <= (row_pos_r == '0);
      lastrow_r <= last_row;
      lastcol_r <= last_col;
      col_r     <= col_pos_r;
    end
    if (cmd.prod) begin
      wx_r  <= $signed({1'b0, w_r}) * x_r;
      wxx_r <= 46'(w_r * xx_r);
      wsq_r <= w_r * w_r;
    end
  end

  assign ram_re    = cmd.accept;
  assign ram_raddr = col_pos_r;

  // column entry update
  logic signed [VAL_W-1:0]  b_min, b_max, n_min, n_max;
  logic                     b_vld, n_vld;
  logic signed [SWX_W-1:0]  b_swx, n_swx;
  logic [SWXX_W-1:0]        b_swxx, n_swxx;
  logic [SW_W-1:0]          b_sw, n_sw;
  logic [SWW_W-1:0]         b_sww, n_sww;

  always_comb begin
    {b_min, b_max, b_vld, b_swx, b_swxx, b_sw, b_sww} = ram_rdata;
    if (row0_r) begin
      b_min = '0; b_max = '0; b_vld = 1'b0;
      b_swx = '0; b_swxx = '0; b_sw = '0; b_sww = '0;
    end
    n_min = b_min; n_max = b_max; n_vld = b_vld;
    n_swx = b_swx; n_swxx = b_swxx; n_sw = b_sw; n_sww = b_sww;
    if (use_r) begin
      if (!b_vld) begin
        n_min = x_r; n_max = x_r; n_vld = 1'b1;
      end else begin
        if (x_r < b_min) n_min = x_r;
        if (x_r > b_max) n_max = x_r;
      end
      n_swx  = b_swx + SWX_W'(wx_r);
      n_swxx = b_swxx + SWXX_W'(wxx_r);
      n_sw   = b_sw + SW_W'(w_r);
      n_sww  = b_sww + SWW_W'(wsq_r);
    end
  end

  assign ram_we    = cmd.upd;
  assign ram_waddr = col_r;
  assign ram_wdata = {n_min, n_max, n_vld, n_swx, n_swxx, n_sw, n_sww};

  logic signed [SWX_W-1:0] e_swx_r;
  logic [SWXX_W-1:0]       e_swxx_r;
  logic [SW_W-1:0]         e_sw_r;
  logic [SWW_W-1:0]        e_sww_r;

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      e_swx_r  <= n_swx;
      e_swxx_r <= n_swxx;
      e_sw_r   <= n_sw;
      e_sww_r  <= n_sww;
    end
  end

  // result in progress
  logic signed [STAT_W-1:0] res_val_r;
  logic                     res_miss_r;
  logic signed [STAT_W-1:0] miss_val;
  logic                     is_var;

  assign miss_val = {{(STAT_W-VAL_W-8){missing_value_r[VAL_W-1]}}, missing_value_r, 8'h00};
  assign is_var   = (statistic_r == STAT_PVAR) || (statistic_r == STAT_SVAR);

  // bit-serial multiplier, three products in turn
  logic [1:0]      mul_phase_r;
  logic [P_W-1:0]  mcand_r, acc_r, acc_nxt;
  logic [MB_W-1:0] mplier_r;
  logic [MCW-1:0]  mul_cnt_r;
  logic [MB_W-1:0] mag;
  logic [P_W-1:0]  prod_a_r, prod_b_r;
  logic [WW_W-1:0] ww_r;
  logic [MA_W-1:0] op_a;
  logic [MB_W-1:0] op_b;

  always_comb begin
    mag = e_swx_r[SWX_W-1] ? MB_W'(-e_swx_r) : MB_W'(e_swx_r);
    case (mul_phase_r)
      2'd0:    begin op_a = e_swxx_r;      op_b = MB_W'(e_sw_r); end
      2'd1:    begin op_a = MA_W'(mag);    op_b = mag;           end
      default: begin op_a = MA_W'(e_sw_r); op_b = MB_W'(e_sw_r); end
    endcase
    acc_nxt = mplier_r[0] ? acc_r + mcand_r : acc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_phase_r <= 2'd0;
      mul_cnt_r   <= '0;
    end else if (cmd.upd) begin
      mul_phase_r <= 2'd0;
    end else if (cmd.mul_go) begin
      mul_cnt_r <= MCW'(MB_W);
    end else if (cmd.mul_step) begin
      mul_cnt_r <= mul_cnt_r - MCW'(1);
      if (mul_cnt_r == MCW'(1)) mul_phase_r <= mul_phase_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_go) begin
      mcand_r  <= P_W'(op_a);
      mplier_r <= op_b;
      acc_r    <= '0;
    end else if (cmd.mul_step) begin
      acc_r    <= acc_nxt;
      mcand_r  <= mcand_r << 1;
      mplier_r <= mplier_r >> 1;
      if (mul_cnt_r == MCW'(1)) begin
        case (mul_phase_r)
          2'd0:    prod_a_r <= acc_nxt;
          2'd1:    prod_b_r <= acc_nxt;
          default: ww_r     <= WW_W'(acc_nxt);
        endcase
      end
    end
  end

  // restoring divider, one quotient bit per cycle
  logic [NUM_W-1:0]  num_r;
  logic [WW_W-1:0]   den_r, den;
  logic [WW_W:0]     rem_r, rem_sh, rem_nxt;
  logic [STAT_W-1:0] q_r, q_nxt;
  logic              ovf_r, ovf_nxt, qbit;
  logic [DCW-1:0]    div_cnt_r;
  logic              var_miss;

  always_comb begin
    if (statistic_r == STAT_PVAR) begin
      var_miss = (e_sw_r == '0);
      den      = ww_r;
    end else begin
      var_miss = (ww_r <= WW_W'(e_sww_r));
      den      = ww_r - WW_W'(e_sww_r);
    end
    rem_sh  = {rem_r[WW_W-1:0], num_r[NUM_W-1]};
    qbit    = rem_sh >= {1'b0, den_r};
    rem_nxt = qbit ? rem_sh - {1'b0, den_r} : rem_sh;
    q_nxt   = {q_r[STAT_W-2:0], qbit};
    ovf_nxt = ovf_r | q_r[STAT_W-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else if (cmd.prep) begin
      div_cnt_r <= DCW'(NUM_W);
    end else if (cmd.div_step) begin
      div_cnt_r <= div_cnt_r - DCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      num_r <= (prod_a_r >= prod_b_r) ? {prod_a_r - prod_b_r, 8'h00} : '0;
      den_r <= den;
      rem_r <= '0;
      q_r   <= '0;
      ovf_r <= 1'b0;
    end else if (cmd.div_step) begin
      num_r <= num_r << 1;
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  // result register: loaded at update, at prep when the variance is missing, or at the final divide step
  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      res_miss_r <= 1'b0;
      res_val_r  <= '0;
      if (statistic_r == STAT_MIN || statistic_r == STAT_MAXV ||
          statistic_r == STAT_RANGE) begin
        if (!n_vld) begin
          res_miss_r <= 1'b1;
          res_val_r  <= miss_val;
        end else begin
          case (statistic_r)
            STAT_MIN:  res_val_r <= STAT_W'(n_min) <<< 8;
            STAT_MAXV: res_val_r <= STAT_W'(n_max) <<< 8;
            default:   res_val_r <= (STAT_W'(n_max) - STAT_W'(n_min)) <<< 8;
          endcase
        end
      end
    end else if (cmd.prep && var_miss) begin
      res_miss_r <= 1'b1;
      res_val_r  <= miss_val;
    end else if (cmd.div_step && div_cnt_r == DCW'(1)) begin
      res_val_r <= (ovf_nxt || q_nxt[STAT_W-1]) ? STAT_MAX : q_nxt;
    end
  end

  // output register and missing count
  logic [MISS_W-1:0] miss_count_r, miss_tot;
  logic              out_valid_r;

  assign miss_tot = miss_count_r + MISS_W'(res_miss_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      miss_count_r <= '0;
    end else begin
      if (cmd.load_out) begin
        out_valid_r  <= 1'b1;
        miss_count_r <= lastcol_r ? '0 : miss_tot;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_column_index  <= CIDX_W'(col_r);
      out_stat_value    <= res_val_r;
      out_is_missing    <= res_miss_r;
      out_last_column   <= lastcol_r;
      out_missing_total <= miss_tot;
    end
  end

  assign out_valid = out_valid_r;

  assign sts.last_row = lastrow_r;
  assign sts.is_var   = is_var;
  assign sts.mul_done = (mul_cnt_r == MCW'(1));
  assign sts.mul_last = (mul_phase_r == 2'd2);
  assign sts.var_miss = var_miss;
  assign sts.div_done = (div_cnt_r == DCW'(1));
  assign sts.out_free = !out_valid_r || !out_stall;

  `CSR_ASSERT_IMP(a_no_overwrite, cmd.load_out, !out_valid_r || !out_stall, "result overwritten")
  `CSR_ASSERT_IMP(a_mul_count, cmd.mul_step, mul_cnt_r != '0, "multiplier stepped past end")
  `CSR_ASSERT_IMP(a_div_count, cmd.div_step, div_cnt_r != '0, "divider stepped past end")

endmodule

// File: src/column_statistics_reduction_top.sv
// Top level of the column statistics reduction block.
//
//  channel | direction | handshake           | payload
//  in_     | input     | in_valid / in_stall   | sample_value, sample_weight
//  out_    | output    | out_valid / out_stall | column_index, stat_value, is_missing,
//          |           |                       | last_column, missing_total
//  cfg_    | input     | cfg_we                | cfg_index, cfg_data
//
// An item not on the last row passes through accept, column store read and update.
// Last row with min, max or range: accept, column store read, update, then the output handoff.
// Last row with a variance: the bit-serial multiplier forms the three wide products with an
//   MB = 33 + log2(MAX_ROWS) bit multiplier, then the restoring divider works through a
//   NUM = 87 + 2*log2(MAX_ROWS) bit dividend unless the variance is missing.
// Reset (rst_n low, synchronous) clears positions, counts, config and state; column
//   stores are loaded on row zero and need no clearing.
// A result waits in the output register under out_stall; the next item is taken
//   meanwhile and only its own emit waits for the register to free.
module column_statistics_reduction_top #(
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_ROWS    = 4096
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [csr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [csr_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [csr_pkg::VAL_W-1:0]  in_sample_value,
  input  logic [csr_pkg::WGT_W-1:0]         in_sample_weight,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [csr_pkg::CIDX_W-1:0]        out_column_index,
  output logic signed [csr_pkg::STAT_W-1:0] out_stat_value,
  output logic                              out_is_missing,
  output logic                              out_last_column,
  output logic [csr_pkg::MISS_W-1:0]        out_missing_total
);
  import csr_pkg::*;

  localparam int RB    = $clog2(MAX_ROWS);
  localparam int CPW   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  // packed column entry: min, max, valid, sum wx, sum wxx, sum w, sum ww
  localparam int ENT_W = 33 + (33 + RB) + (46 + RB) + (16 + RB) + (32 + RB);

  ctl_cmd_t         cmd;
  dp_sts_t          sts;
  logic             ram_we, ram_re;
  logic [CPW-1:0]   ram_waddr, ram_raddr;
  logic [ENT_W-1:0] ram_wdata, ram_rdata;

  csr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  csr_datapath #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_sample_value   (in_sample_value),
    .in_sample_weight  (in_sample_weight),
    .cmd               (cmd),
    .sts               (sts),
    .ram_we            (ram_we),
    .ram_waddr         (ram_waddr),
    .ram_wdata         (ram_wdata),
    .ram_re            (ram_re),
    .ram_raddr         (ram_raddr),
    .ram_rdata         (ram_rdata),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_column_index  (out_column_index),
    .out_stat_value    (out_stat_value),
    .out_is_missing    (out_is_missing),
    .out_last_column   (out_last_column),
    .out_missing_total (out_missing_total)
  );

  // one entry per column holds all running statistics
  csr_ram #(
    .WIDTH (ENT_W),
    .DEPTH (1 << CPW)
  ) u_col_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// File: bench/csr_checker.sv
// Predicts column statistics results and compares them with the block's output.
`timescale 1ns / 1ps

module csr_checker (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [csr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [csr_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                               in_valid,
  input  wire logic                               in_stall,
  input  wire logic signed [csr_pkg::VAL_W-1:0]   in_sample_value,
  input  wire logic [csr_pkg::WGT_W-1:0]          in_sample_weight,
  input  wire logic                               out_valid,
  input  wire logic                               out_stall,
  input  wire logic [csr_pkg::CIDX_W-1:0]         out_column_index,
  input  wire logic signed [csr_pkg::STAT_W-1:0]  out_stat_value,
  input  wire logic                               out_is_missing,
  input  wire logic                               out_last_column,
  input  wire logic [csr_pkg::MISS_W-1:0]         out_missing_total,
  output int                                      fail_count,
  output int                                      pending,
  output int                                      checked
);
  import csr_pkg::*;

  typedef struct {
    logic [CIDX_W-1:0]        col;
    logic signed [STAT_W-1:0] value;
    logic                     miss;
    logic                     last_col;
    logic [MISS_W-1:0]        miss_total;
  } col_result_t;

  col_result_t column_results_q[$];

  // shadow registers
  logic [CC_W-1:0]         ncols_r;
  logic [RC_W-1:0]         nrows_r;
  logic [SEL_W-1:0]        stat_r;
  logic                    skip_r;
  logic signed [VAL_W-1:0] mval_r;

  // per-column stores
  logic signed [VAL_W-1:0] min_m [1024];
  logic signed [VAL_W-1:0] max_m [1024];
  logic                    seen_m [1024];
  longint                  swx_m [1024];
  longint                  swxx_m [1024];
  longint                  sw_m [1024];
  longint                  sww_m [1024];
  int                      cpos, rpos, mcount;

  task automatic report_mismatch(input string field, input longint got, input longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
    fail_count++;
  endtask

  // Folds one item into its column; returns 1 when a column result comes out.
  function automatic bit reduce_item(input logic signed [VAL_W-1:0] x,
                                     input logic [WGT_W-1:0] w, output col_result_t r);
    int nc, nr, c;
    bit use_it, last_row, last_col, miss;
    longint lx, lw, mag;
    logic [127:0] a, b, ww, sq, num, den, q, mw;
    logic signed [STAT_W-1:0] val;
    nc = ncols_r == 0 ? 1 : (ncols_r > 1024 ? 1024 : ncols_r);
    nr = nrows_r == 0 ? 1 : (nrows_r > 4096 ? 4096 : nrows_r);
    c = cpos;
    lx = longint'(x);
    lw = longint'(w);
    use_it = !(skip_r && x == mval_r);
    if (rpos == 0) begin
      seen_m[c] = use_it;
      min_m[c] = use_it ? x : '0;
      max_m[c] = use_it ? x : '0;
      swx_m[c] = 0; swxx_m[c] = 0; sw_m[c] = 0; sww_m[c] = 0;
    end
    if (use_it) begin
      if (!seen_m[c]) begin
        min_m[c] = x; max_m[c] = x; seen_m[c] = 1'b1;
      end else begin
        if (x < min_m[c]) min_m[c] = x;
        if (x > max_m[c]) max_m[c] = x;
      end
      swx_m[c] += lw * lx;
      swxx_m[c] += lw * lx * lx;
      sw_m[c] += lw;
      sww_m[c] += lw * lw;
    end
    last_row = rpos + 1 >= nr;
    last_col = cpos + 1 >= nc;
    miss = 1'b0;
    val = '0;
    if (last_row) begin
      case (stat_r)
        STAT_MIN, STAT_MAXV, STAT_RANGE: begin
          if (!seen_m[c]) miss = 1'b1;
          else if (stat_r == STAT_MIN) val = STAT_W'(longint'(min_m[c]) * 256);
          else if (stat_r == STAT_MAXV) val = STAT_W'(longint'(max_m[c]) * 256);
          else val = STAT_W'((longint'(max_m[c]) - longint'(min_m[c])) * 256);
        end
        STAT_PVAR, STAT_SVAR: begin
          mag = swx_m[c] < 0 ? -swx_m[c] : swx_m[c];
          a = 128'(swxx_m[c]);
          mw = 128'(sw_m[c]);
          a = a * mw;
          b = 128'(mag);
          b = b * b;
          ww = mw * mw;
          sq = 128'(sww_m[c]);
          num = a >= b ? (a - b) << 8 : '0;
          if (stat_r == STAT_PVAR) begin
            miss = sw_m[c] == 0;
            den = ww;
          end else begin
            miss = ww <= sq;
            den = ww - sq;
          end
          if (!miss) begin
            q = num / den;
            val = q > 128'(STAT_MAX) ? STAT_MAX : q[STAT_W-1:0];
          end
        end
        default: val = '0;
      endcase
      if (miss) begin
        val = STAT_W'(longint'(mval_r) * 256);
        mcount++;
      end
      r.col = CIDX_W'(c);
      r.value = val;
      r.miss = miss;
      r.last_col = last_col;
      r.miss_total = MISS_W'(mcount);
    end
    if (last_col) begin
      cpos = 0;
      if (last_row) begin
        rpos = 0;
        mcount = 0;
      end else begin
        rpos++;
      end
    end else begin
      cpos++;
    end
    return last_row;
  endfunction

  always @(posedge clk) begin
    col_result_t r, e;
    if (!rst_n) begin
      ncols_r = 1; nrows_r = 1; stat_r = STAT_MIN; skip_r = 1'b0; mval_r = -16'sd32768;
      cpos = 0; rpos = 0; mcount = 0;
      column_results_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_COLUMN_COUNT:  ncols_r = cfg_data[CC_W-1:0];
          CFG_ROW_COUNT:     nrows_r = cfg_data[RC_W-1:0];
          CFG_STATISTIC:     stat_r = cfg_data[SEL_W-1:0];
          CFG_SKIP_MISSING:  skip_r = cfg_data[0];
          CFG_MISSING_VALUE: mval_r = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (column_results_q.size() == 0) begin
          // a result with none expected
          report_mismatch("unexpected result count", 1, 0);
        end else begin
          e = column_results_q.pop_front();
          checked++;
          if (out_column_index !== e.col)
            report_mismatch("column_index", out_column_index, e.col);
          if (out_stat_value !== e.value)
            report_mismatch("stat_value", out_stat_value, e.value);
          if (out_is_missing !== e.miss)
            report_mismatch("is_missing", out_is_missing, e.miss);
          if (out_last_column !== e.last_col)
            report_mismatch("last_column", out_last_column, e.last_col);
          if (out_missing_total !== e.miss_total)
            report_mismatch("missing_total", out_missing_total, e.miss_total);
        end
      end
      if (in_valid && !in_stall) begin
        if (reduce_item(in_sample_value, in_sample_weight, r)) column_results_q.push_back(r);
      end
    end
    pending = column_results_q.size();
  end

endmodule

// File: bench/tb.sv
// Testbench top: stimulus, idling and verdict for the column statistics block.
`timescale 1ns / 1ps

module tb;
  import csr_pkg::*;

  localparam int ITEM_TARGET = 1950;
  localparam int SETTLE      = 500;       // longer than a variance item's worst latency
  localparam int LIMIT       = 2_000_000;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic signed [VAL_W-1:0] in_sample_value = '0;
  logic [WGT_W-1:0]        in_sample_weight = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [CIDX_W-1:0]       out_column_index;
  logic signed [STAT_W-1:0] out_stat_value;
  logic                    out_is_missing;
  logic                    out_last_column;
  logic [MISS_W-1:0]       out_missing_total;

  int fail_count, pending, checked;
  int cycles = 0;
  int items_sent = 0;
  int grids = 0;
  int tx_idle_pct = 9;
  int rx_stall_pct = 59;
  bit hold_off = 1'b0;

  always #5 clk = ~clk;

  column_statistics_reduction_top dut (.*);

  csr_checker chk (.*);

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off when asked for.
  always @(posedge clk) out_stall <= hold_off || ($urandom_range(99) < rx_stall_pct);

  // Idling profile follows how far the stimulus has come:
  // sender light / receiver heavy, then swapped, then no idling at all.
  task automatic set_profile();
    if (items_sent < ITEM_TARGET / 3) begin
      tx_idle_pct = 9; rx_stall_pct = 59;
    end else if (items_sent < 2 * ITEM_TARGET / 3) begin
      tx_idle_pct = 59; rx_stall_pct = 9;
    end else begin
      tx_idle_pct = 0; rx_stall_pct = 0;
    end
  endtask

  // Offer one item and return on the edge that accepts it.
  task automatic send_item(input logic signed [VAL_W-1:0] v, input logic [WGT_W-1:0] w);
    set_profile();
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample_value <= v;
    in_sample_weight <= w;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // Block drained: every result in, then time for a last-row item still in flight.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write all five registers, only once the block is idle.
  task automatic configure(input int cols, input int rows, input logic [SEL_W-1:0] stat,
                           input bit skip, input logic signed [VAL_W-1:0] mval);
    logic [CFG_DATA_W-1:0] vals [5];
    logic [CFG_IDX_W-1:0]  idx [5];
    drain();
    idx = '{CFG_COLUMN_COUNT, CFG_ROW_COUNT, CFG_STATISTIC, CFG_SKIP_MISSING,
            CFG_MISSING_VALUE};
    vals = '{CFG_DATA_W'(cols), CFG_DATA_W'(rows), CFG_DATA_W'(stat), CFG_DATA_W'(skip),
             mval};
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    grids++;
  endtask

  function automatic int clamp_count(input int n, input int top);
    return n == 0 ? 1 : (n > top ? top : n);
  endfunction

  // Value mix: extremes, plenty of sentinels when skipping, otherwise anything.
  function automatic logic signed [VAL_W-1:0] pick_value(input bit skip,
                                                         input logic signed [VAL_W-1:0] mval);
    int r;
    r = $urandom_range(9);
    if (r == 0) return -16'sd32768;
    if (r == 1) return 16'sd32767;
    if (r <= 4 && skip) return mval;
    return VAL_W'($urandom);
  endfunction

  function automatic logic [WGT_W-1:0] pick_weight();
    int r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r == 2) return WGT_W'($urandom_range(1, 3));  // tiny weights push sample variance up
    return WGT_W'($urandom);
  endfunction

  // One whole grid of random content, so every grid ends on a clean boundary.
  task automatic random_grid(input int cols, input int rows, input logic [SEL_W-1:0] stat,
                             input bit skip, input logic signed [VAL_W-1:0] mval);
    int n;
    configure(cols, rows, stat, skip, mval);
    n = clamp_count(cols, 1024) * clamp_count(rows, 4096);
    repeat (n) send_item(pick_value(skip, mval), pick_weight());
  endtask

  initial begin
    int cols, rows, r;
    logic [SEL_W-1:0] stat;
    logic signed [VAL_W-1:0] mval;
    bit pressure_done;
    pressure_done = 1'b0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset configuration: one column, one row, minimum.
    send_item(-16'sd1234, 16'h8000);

    // Range with skipping: column 0 entirely missing, column 1 at the extremes.
    configure(2, 2, STAT_RANGE, 1'b1, -16'sd32768);
    send_item(-16'sd32768, 16'hffff);
    send_item(16'sd32767, 16'h0001);
    send_item(-16'sd32768, 16'h0000);
    send_item(-16'sd32767, 16'hffff);

    // Population variance across extreme values and a zero weight.
    configure(1, 3, STAT_PVAR, 1'b0, 16'sd0);
    send_item(16'sd32767, 16'hffff);
    send_item(-16'sd32768, 16'hffff);
    send_item(16'sd0, 16'h0000);

    // Sample variance on a single row: no degrees of freedom, so missing.
    configure(2, 1, STAT_SVAR, 1'b0, 16'sd32767);
    send_item(16'sd5, 16'h1234);
    send_item(-16'sd5, 16'h0000);

    // Zero counts act as one; unknown statistic reads zero.
    configure(0, 0, 3'd7, 1'b1, -16'sd1);
    send_item(-16'sd1, 16'hffff);

    // Max with the sentinel at the top of the range.
    configure(1, 2, STAT_MAXV, 1'b1, 16'sd32767);
    send_item(16'sd32767, 16'h00ff);
    send_item(16'sd5, 16'h0f00);

    // Population variance with all weights zero: missing.
    configure(1, 2, STAT_PVAR, 1'b0, 16'sh5555);
    send_item(16'sd100, 16'h0000);
    send_item(-16'sd100, 16'h0000);

    // Sample variance with unit weights at the extremes: just under saturation.
    configure(1, 2, STAT_SVAR, 1'b0, 16'sh2aaa);
    send_item(16'sd32767, 16'h0001);
    send_item(-16'sd32768, 16'h0001);

    // Column count beyond the maximum acts as 1024; one result per item.
    random_grid(2047, 1, STAT_RANGE, 1'b1, 16'sd0);

    while (items_sent < ITEM_TARGET) begin
      if (!pressure_done && items_sent >= 2 * ITEM_TARGET / 3) begin
        // Receiver holds off long enough to fill the block and stall the input.
        configure(40, 1, STAT_MIN, 1'b0, 16'sd0);
        pressure_done = 1'b1;
        fork
          begin
            hold_off = 1'b1;
            repeat (400) @(posedge clk);
            hold_off = 1'b0;
          end
        join_none
        repeat (40) send_item(pick_value(1'b0, 16'sd0), pick_weight());
      end else begin
        cols = $urandom_range(0, 12);
        rows = $urandom_range(0, 8);
        if ($urandom_range(19) == 0) rows = 8191 - $urandom_range(0, 1) * 8187;  // 8191 or 4
        if (rows > 8) rows = clamp_count(rows, 4096) > 8 ? 4 : rows;
        r = $urandom_range(15);
        stat = r < 14 ? SEL_W'(r % 5) : SEL_W'($urandom_range(5, 7));
        r = $urandom_range(3);
        mval = r == 0 ? -16'sd32768 : (r == 1 ? 16'sd32767 : VAL_W'($urandom));
        random_grid(cols, rows, stat, $urandom_range(1), mval);
      end
    end

    // Wind down and give the verdict.
    drain();
    $display("Run covered %0d items over %0d grid settings with %0d column results checked.",
             items_sent, grids, checked);
    $display("Statistics min/max/range/variance/unknown, skipping on and off, varied idling.");
    if (fail_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
